// ===== design/bmr_pkg.sv =====
// Shared types and constants for the button macro record/replay unit.
package bmr_pkg;

   localparam int MACRO_DEPTH = 256;
   localparam int IDX_W = $clog2(MACRO_DEPTH);
   localparam int CNT_W = $clog2(MACRO_DEPTH + 1);

   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] buttons;
      logic        macro_key;
   } req_type;

   typedef struct packed {
      logic [15:0] pad_buttons;
      logic        is_recording;
      logic        is_playing;
      logic        entry_dropped;
   } rsp_type;

   typedef struct packed {
      logic [15:0] buttons;
      logic [31:0] duration;
   } entry_type;

endpackage

// ===== design/bmr_entry_ram.sv =====
// Macro entry table: one write port, one registered read port with write bypass.
module bmr_entry_ram (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [bmr_pkg::IDX_W-1:0] wr_addr,
   input  bmr_pkg::entry_type       wr_data,
   input  logic [bmr_pkg::IDX_W-1:0] rd_addr,
   output bmr_pkg::entry_type       rd_data
);
   import bmr_pkg::*;

   entry_type mem [MACRO_DEPTH];
   entry_type rd_q_ff;
   entry_type byp_data_ff;
   logic      byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

// ===== design/bmr_rsp_queue.sv =====
// Two-entry response queue between the update logic and the rsp channel.
module bmr_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bmr_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmr_pkg::rsp_type rsp_payload
);
   import bmr_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign full        = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== design/button_macro_record_replay_unit.sv =====
// Button macro record/replay unit: top level with key, record and replay logic.
// A response is pushed into the response queue when its request transaction is accepted.
// Throughput: one request per cycle while the queue has room; the entry table read is
// prefetched at replay index; one table access per poll, write bypassed to same-entry read.
// Reset (synchronous): clears all control state, loads long_press_ms with 1000;
// the entry table is not cleared and needs no clearing pass.
module button_macro_record_replay_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bmr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmr_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata
);
   import bmr_pkg::*;

   logic [15:0]      long_press_ff;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] replay_index_ff, replay_index_in;
   logic             recording_on_ff, recording_on_in;
   logic             playing_on_ff, playing_on_in;
   logic             key_held_ff, key_held_in;
   logic [31:0]      press_start_ff, press_start_in;
   logic [31:0]      last_change_ff, last_change_in;
   logic [15:0]      held_state_ff, held_state_in;
   logic [15:0]      replay_buttons_ff, replay_buttons_in;
   logic [31:0]      replay_deadline_ff, replay_deadline_in;

   logic             req_accept;
   logic             queue_full;
   logic [31:0]      now;
   logic [15:0]      manual;
   logic [31:0]      hold;
   logic             append_en;
   logic [15:0]      append_word;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   entry_type        rd_data;
   entry_type        cur_entry;
   logic             dropped;
   rsp_type          rsp_in;

   assign req_ready  = !queue_full;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign now        = req_payload.now_ms;
   assign manual     = req_payload.buttons;
   assign hold       = now - press_start_ff;

   always_comb begin
      entry_count_in     = entry_count_ff;
      replay_index_in    = replay_index_ff;
      recording_on_in    = recording_on_ff;
      playing_on_in      = playing_on_ff;
      key_held_in        = key_held_ff;
      press_start_in     = press_start_ff;
      last_change_in     = last_change_ff;
      held_state_in      = held_state_ff;
      replay_buttons_in  = replay_buttons_ff;
      replay_deadline_in = replay_deadline_ff;
      append_en          = 1'b0;
      append_word        = held_state_ff;
      wr_en              = 1'b0;
      dropped            = 1'b0;
      wr_addr            = entry_count_ff[IDX_W-1:0];
      wr_data.buttons    = held_state_ff;
      wr_data.duration   = 32'd0;
      cur_entry          = rd_data;

      if (req_accept) begin
         if (req_payload.macro_key) begin
            if (!key_held_ff) begin
               key_held_in    = 1'b1;
               press_start_in = now;
            end
         end else if (key_held_ff) begin
            key_held_in = 1'b0;
            if (hold > 32'(long_press_ff)) begin
               recording_on_in = !recording_on_ff;
               if (!recording_on_ff) begin
                  entry_count_in = '0;
                  held_state_in  = manual;
                  last_change_in = now;
               end else begin
                  append_en   = 1'b1;
                  append_word = held_state_ff;
               end
            end else if (entry_count_ff != '0) begin
               playing_on_in = 1'b1;
            end
         end

         if (recording_on_in && (manual != held_state_in)) begin
            append_en     = 1'b1;
            append_word   = held_state_in;
            held_state_in = manual;
         end

         // append: table write, or drop when full
         wr_addr          = entry_count_in[IDX_W-1:0];
         wr_data.buttons  = append_word;
         wr_data.duration = now - last_change_in;
         if (append_en) begin
            if (entry_count_in != CNT_W'(MACRO_DEPTH)) begin
               wr_en          = 1'b1;
               entry_count_in = entry_count_in + CNT_W'(1);
            end else begin
               dropped = 1'b1;
            end
            last_change_in = now;
         end

         if (wr_en && (wr_addr == replay_index_ff[IDX_W-1:0])) begin
            cur_entry = wr_data;
         end

         if (playing_on_in && (now >= replay_deadline_ff)) begin
            if (replay_index_ff >= entry_count_in) begin
               playing_on_in     = 1'b0;
               replay_index_in   = '0;
               replay_buttons_in = '0;
            end else begin
               replay_buttons_in  = cur_entry.buttons;
               replay_deadline_in = now + cur_entry.duration;
               replay_index_in    = replay_index_ff + CNT_W'(1);
            end
         end
      end

      rsp_in.pad_buttons   = manual | replay_buttons_in;
      rsp_in.is_recording  = recording_on_in;
      rsp_in.is_playing    = playing_on_in;
      rsp_in.entry_dropped = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff      <= LONG_PRESS_RESET;
         entry_count_ff     <= '0;
         replay_index_ff    <= '0;
         recording_on_ff    <= 1'b0;
         playing_on_ff      <= 1'b0;
         key_held_ff        <= 1'b0;
         press_start_ff     <= '0;
         last_change_ff     <= '0;
         held_state_ff      <= '0;
         replay_buttons_ff  <= '0;
         replay_deadline_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            long_press_ff <= csr_wdata;
         end
         entry_count_ff     <= entry_count_in;
         replay_index_ff    <= replay_index_in;
         recording_on_ff    <= recording_on_in;
         playing_on_ff      <= playing_on_in;
         key_held_ff        <= key_held_in;
         press_start_ff     <= press_start_in;
         last_change_ff     <= last_change_in;
         held_state_ff      <= held_state_in;
         replay_buttons_ff  <= replay_buttons_in;
         replay_deadline_ff <= replay_deadline_in;
      end
   end

   bmr_entry_ram u_entry_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (replay_index_in[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   bmr_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (req_accept),
      .push_data   (rsp_in),
      .full        (queue_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(MACRO_DEPTH))
      else $error("entry count exceeds table depth");

   a_idle_replay_clear: assert property (@(posedge clock) disable iff (reset)
      !playing_on_ff |-> (replay_index_ff == '0) && (replay_buttons_ff == '0))
      else $error("replay state not cleared while idle");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      dropped |-> (entry_count_in == CNT_W'(MACRO_DEPTH)) && !wr_en)
      else $error("append dropped with room in table");

   a_write_on_append: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (entry_count_ff != '0))
      else $error("table write did not advance entry count");
`endif

endmodule
